FILE: src/soft_knee_sample_limiter_assert.svh
// Assertion macros for the soft-knee sample limiter.
`ifndef SOFT_KNEE_SAMPLE_LIMITER_ASSERT_SVH
`define SOFT_KNEE_SAMPLE_LIMITER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SKL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("soft knee limiter check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SKL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("soft knee limiter check failed");

`endif

FILE: src/skl_pkg.sv
// Constants and register codes for the soft-knee sample limiter.
`default_nettype none
package skl_pkg;

  localparam int GAIN_W = 16;

  localparam logic [GAIN_W-1:0] GAIN_MIN     = 16'd410;
  localparam logic [GAIN_W-1:0] GAIN_RESET   = 16'd4096;
  localparam logic [GAIN_W-1:0] SMOOTH_MAX   = 16'd32768;
  localparam logic [GAIN_W-1:0] SMOOTH_RESET = 16'd32768;

  typedef enum logic [0:0] {
    REG_GAIN   = 1'b0,
    REG_SMOOTH = 1'b1
  } reg_index_t;

endpackage
`default_nettype wire

FILE: src/soft_knee_sample_limiter.sv
// Top level of the soft-knee sample limiter: gain, knee curve, pipelined divider.
//
//   channel  | handshake         | payload
//   ---------+-------------------+------------------------------------------
//   s_*      | s_tvalid/s_tready | s_tdata: sample_in (signed)
//   m_*      | m_tvalid/m_tready | m_tdata: sample_out (signed)
//   cfg_*    | cfg_valid/ready   | cfg_index, cfg_data (gain, smooth)
//
// One item per cycle while the output is not stalled; the restoring divider
// retires one quotient bit per stage.
// rst clears all valid bits and loads gain 1.0 and smooth 1.0.
// A stalled output freezes the whole pipeline; s_tready and cfg_ready stay low in rst.
`default_nettype none
`include "soft_knee_sample_limiter_assert.svh"
module soft_knee_sample_limiter #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,   // sample_in
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,   // sample_out
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  skl_pkg::reg_index_t                 cfg_index,
  input  logic [skl_pkg::GAIN_W-1:0]          cfg_data
);
  import skl_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int TW = ((SAMPLE_BITS+7)/8)*8;
  localparam int PW = SAMPLE_BITS+17;
  localparam int AW = SAMPLE_BITS+5;
  localparam int MW = SAMPLE_BITS+4;
  localparam logic [SB-1:0] LIM = {1'b0, {(SB-1){1'b1}}};

  typedef struct packed {
    logic          neg;
    logic          lin;
    logic          sat;
    logic [SB-1:0] mag;
  } side_t;

  // configuration
  logic [GAIN_W-1:0] gain;
  logic [GAIN_W-1:0] smooth;
  logic [SB-2:0]     w;
  logic [SB+14:0]    wprod;
  logic [SB-2:0]     lo;
  logic [SB-1:0]     hi;
  logic [SB:0]       den;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain   <= GAIN_RESET;
      smooth <= SMOOTH_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GAIN:   gain   <= (cfg_data < GAIN_MIN) ? GAIN_MIN : cfg_data;
        REG_SMOOTH: smooth <= (cfg_data > SMOOTH_MAX) ? SMOOTH_MAX : cfg_data;
      endcase
    end
  end

  assign wprod = {smooth, {(SB-1){1'b0}}} - (SB+15)'(smooth);

  always_ff @(posedge clk) begin
    if (rst) begin
      w <= LIM[SB-2:0];
    end else begin
      w <= wprod[SB+13:15];
    end
  end

  assign lo  = LIM[SB-2:0] - w;
  assign hi  = {1'b0, LIM[SB-2:0]} + {1'b0, w};
  assign den = {w, 2'b00};

  // pipeline control
  logic en;
  logic v1, v2, v3, v4, v5, vf;
  logic [SB-1:0] dv;
  logic out_valid;

  assign en       = !out_valid || m_tready;
  assign s_tready = en && !rst;
  assign m_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      dv <= '0;
      vf <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      dv <= {dv[SB-2:0], v5};
      vf <= dv[SB-1];
      out_valid <= vf;
    end
  end

  // stage 1: gain
  logic signed [PW-1:0] p1;
  logic signed [PW-1:0] p_next;
  assign p_next = $signed(s_tdata[SB-1:0]) * $signed({1'b0, gain});

  // stage 2: divide by 4096 toward zero
  logic signed [AW-1:0] a2;
  logic signed [PW-1:0] psum;
  assign psum = p1 + (p1[PW-1] ? PW'(4095) : PW'(0));

  // stage 3: magnitude
  logic          neg3;
  logic [MW-1:0] mag3;
  logic [AW-1:0] a_abs;
  assign a_abs = a2[AW-1] ? AW'(-a2) : AW'(a2);

  // stage 4: classify
  side_t         side4;
  logic [SB-1:0] d4;
  logic          lin_c;
  logic          over_c;
  logic [MW-1:0] dd;
  assign lin_c  = mag3 < MW'(lo);
  assign over_c = (mag3 > MW'(hi)) || (w == '0);
  assign dd     = mag3 - MW'(lo);

  // stage 5: square
  side_t           side5;
  logic [2*SB-1:0] sq5;
  logic [2*SB-1:0] sq_next;
  assign sq_next = d4 * d4;

  always_ff @(posedge clk) begin
    if (en) begin
      p1        <= p_next;
      a2        <= psum[PW-1:12];
      neg3      <= a2[AW-1];
      mag3      <= a_abs[MW-1:0];
      side4.neg <= neg3;
      side4.lin <= lin_c;
      side4.sat <= !lin_c && over_c;
      side4.mag <= mag3[SB-1:0];
      d4        <= dd[SB-1:0];
      side5     <= side4;
      sq5       <= sq_next;
    end
  end

  // divider stages, one quotient bit each
  side_t         dside [SB];
  logic [SB:0]   drem  [SB];
  logic [SB-1:0] dlo   [SB];
  logic [SB-1:0] dquo  [SB];

  for (genvar k = 0; k < SB; k++) begin : g_div
    side_t         sin;
    logic [SB:0]   rin;
    logic [SB-1:0] lin_bits;
    logic [SB-1:0] qin;
    logic [SB+1:0] trial;
    logic [SB+1:0] diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign sin      = side5;
      assign rin      = {1'b0, sq5[2*SB-1:SB]};
      assign lin_bits = sq5[SB-1:0];
      assign qin      = '0;
    end else begin : g_rest
      assign sin      = dside[k-1];
      assign rin      = drem[k-1];
      assign lin_bits = dlo[k-1];
      assign qin      = dquo[k-1];
    end

    assign trial = {rin, lin_bits[SB-1]};
    assign ge    = trial >= {1'b0, den};
    assign diff  = trial - {1'b0, den};

    always_ff @(posedge clk) begin
      if (en) begin
        dside[k] <= sin;
        drem[k]  <= ge ? diff[SB:0] : trial[SB:0];
        dlo[k]   <= {lin_bits[SB-2:0], 1'b0};
        dquo[k]  <= {qin[SB-2:0], ge};
      end
    end
  end

  // final magnitude and sign
  side_t         sl;
  logic          negf;
  logic [SB-1:0] magf;
  logic [SB-1:0] mag_next;
  logic [SB-1:0] out_data;
  assign sl = dside[SB-1];

  always_comb begin
    if (sl.lin) begin
      mag_next = sl.mag;
    end else if (sl.sat) begin
      mag_next = LIM;
    end else begin
      mag_next = sl.mag - dquo[SB-1] - SB'(drem[SB-1] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      negf     <= sl.neg;
      magf     <= mag_next;
      out_data <= negf ? SB'(-magf) : magf;
    end
  end

  assign m_tdata = TW'(out_data);

  // checks
  logic [SB+6:0] vld_all;
  assign vld_all = {v1, v2, v3, v4, v5, dv, vf, out_valid};

  `SKL_ASSERT_NOW(a_out_in_range, out_valid, out_data != {1'b1, {(SB-1){1'b0}}})
  `SKL_ASSERT_NEXT(a_stall_freezes, out_valid && !m_tready, $stable(vld_all))
  `SKL_ASSERT_NOW(a_knee_nonzero_w, v4 && !side4.lin && !side4.sat, w != '0)
  `SKL_ASSERT_NOW(a_rem_below_den, dv[SB-1] && !sl.lin && !sl.sat, drem[SB-1] < den)

endmodule
`default_nettype wire

FILE: bench/testbench.sv
// Self-checking stream testbench for the soft-knee sample limiter.
`timescale 1ns / 1ps
module testbench;
  import skl_pkg::*;

  localparam int SAMPLE_W = 24;
  localparam int LATENCY = SAMPLE_W + 7;
  localparam longint LIMIT = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PRINT_CAP = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [SAMPLE_W-1:0] s_tdata = '0;  // sample_in
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [SAMPLE_W-1:0] m_tdata;       // sample_out
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  reg_index_t cfg_index = REG_GAIN;
  logic [GAIN_W-1:0] cfg_data = '0;

  logic [GAIN_W-1:0] gain_reg = GAIN_RESET;
  logic [GAIN_W-1:0] smooth_reg = SMOOTH_RESET;
  logic [SAMPLE_W-1:0] expected_limited[$];
  logic [SAMPLE_W-1:0] want;
  int errors = 0;
  int cycle_count = 0;
  int sink_hold_req = 0;
  int sink_stall = 0;
  bit src_idle_en = 1'b1;
  bit sink_idle_en = 1'b1;

  soft_knee_sample_limiter #(.SAMPLE_BITS(SAMPLE_W)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint eff_gain();
    return (gain_reg < GAIN_MIN) ? longint'(GAIN_MIN) : longint'(gain_reg);
  endfunction

  function automatic longint knee_half_width();
    longint s;
    s = (smooth_reg > SMOOTH_MAX) ? longint'(SMOOTH_MAX) : longint'(smooth_reg);
    return (LIMIT * s) / 32768;
  endfunction

  function automatic logic [SAMPLE_W-1:0] limit_sample(input logic [SAMPLE_W-1:0] raw);
    logic signed [SAMPLE_W-1:0] xs;
    longint x, w, amp, mag, lo, hi, res, d, den, q;
    logic neg;
    xs = raw;
    x = xs;
    w = knee_half_width();
    amp = (x * eff_gain()) / 4096;
    neg = amp < 0;
    mag = neg ? -amp : amp;
    lo = LIMIT - w;
    hi = LIMIT + w;
    if (mag < lo) begin
      res = mag;
    end else if (mag > hi || w == 0) begin
      res = LIMIT;
    end else begin
      d = mag - lo;
      den = 4 * w;
      q = (d * d + den - 1) / den;
      res = mag - q;
    end
    if (neg) begin
      res = -res;
    end
    return res[SAMPLE_W-1:0];
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    longint x, t, w;
    w = knee_half_width();
    x = 0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: x = longint'($urandom_range(0, (1 << SAMPLE_W) - 1)) - (1 << (SAMPLE_W - 1));
      4: x = longint'($urandom_range(0, 2000)) - 1000;
      5: begin
        case ($urandom_range(0, 3))
          0: x = LIMIT;
          1: x = -LIMIT - 1;
          2: x = -LIMIT;
          default: x = 0;
        endcase
      end
      default: begin
        case ($urandom_range(0, 2))
          0: t = LIMIT - w;
          1: t = LIMIT + w;
          default: t = LIMIT;
        endcase
        t = t + longint'($urandom_range(0, 64)) - 32;
        x = (t * 4096) / eff_gain();
        if ($urandom_range(0, 1)) begin
          x = -x;
        end
      end
    endcase
    if (x > LIMIT) begin
      x = LIMIT;
    end else if (x < -LIMIT - 1) begin
      x = -LIMIT - 1;
    end
    return x[SAMPLE_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] got,
                                 input logic [SAMPLE_W-1:0] exp_v);
    if (errors < PRINT_CAP) begin
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what,
               $signed(got), $signed(exp_v), cycle_count);
    end
    errors++;
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] x);
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= x;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_limited.push_back(limit_sample(x));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_limited.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [GAIN_W-1:0] val);
    wait_drained();
    repeat (LATENCY) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_GAIN) begin
      gain_reg = val;
    end else begin
      smooth_reg = val;
    end
  endtask

  task automatic test_reset_defaults();
    logic [SAMPLE_W-1:0] pts [8] = '{24'h000000, 24'h000001, 24'hFFFFFF, 24'h7FFFFF,
                                    24'h800000, 24'h400000, 24'hC00000, 24'h000003};
    foreach (pts[i]) send_sample(pts[i]);
  endtask

  task automatic test_gain_floor();
    write_reg(REG_GAIN, 16'd0);
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
    send_sample(24'h003039);
    write_reg(REG_GAIN, 16'd409);
    send_sample(24'h7FFFFF);
    write_reg(REG_GAIN, 16'hFFFF);
    send_sample(24'h000001);
    send_sample(24'hFFFFFF);
    send_sample(24'h0001FF);
    send_sample(24'h7FFFFF);
  endtask

  task automatic test_smooth_ceiling();
    write_reg(REG_GAIN, GAIN_RESET);
    write_reg(REG_SMOOTH, 16'hFFFF);
    send_sample(24'h7FFFFF);
    send_sample(24'h800001);
    send_sample(24'h200000);
  endtask

  task automatic test_zero_knee();
    write_reg(REG_SMOOTH, 16'd0);
    send_sample(24'h7FFFFF);
    send_sample(24'h800001);
    send_sample(24'h800000);
    send_sample(24'h7FFFFE);
    send_sample(24'h000000);
  endtask

  task automatic random_config();
    logic [GAIN_W-1:0] g, s;
    case ($urandom_range(0, 5))
      0: g = 16'd0;
      1: g = GAIN_MIN;
      2: g = 16'hFFFF;
      3: g = 16'($urandom_range(0, 65535));
      default: g = 16'($urandom_range(2048, 16384));
    endcase
    case ($urandom_range(0, 5))
      0: s = 16'd0;
      1: s = SMOOTH_MAX;
      2: s = 16'hFFFF;
      3: s = 16'd1;
      default: s = 16'($urandom_range(0, 65535));
    endcase
    write_reg(REG_GAIN, g);
    write_reg(REG_SMOOTH, s);
  endtask

  task automatic test_random_settings(input int phases, input int per_phase);
    for (int p = 0; p < phases; p++) begin
      random_config();
      repeat (per_phase) send_sample(pick_sample());
    end
  endtask

  task automatic test_output_holdoff();
    random_config();
    src_idle_en = 1'b0;
    sink_hold_req = 300;
    repeat (150) send_sample(pick_sample());
    src_idle_en = 1'b1;
  endtask

  task automatic test_sender_pause();
    repeat (60) send_sample(pick_sample());
    wait_drained();
    repeat (60) send_sample(pick_sample());
  endtask

  task automatic test_full_rate();
    random_config();
    wait_drained();
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    repeat (200) send_sample(pick_sample());
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (sink_hold_req > 0) begin
      sink_stall = sink_hold_req - 1;
      sink_hold_req = 0;
      m_tready <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      m_tready <= 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
      sink_stall = $urandom_range(1, 9) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_limited.size() == 0) begin
        report_mismatch("unexpected sample_out", m_tdata, '0);
      end else begin
        want = expected_limited.pop_front();
        if (m_tdata !== want) begin
          report_mismatch("sample_out", m_tdata, want);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL soft_knee_sample_limiter");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_gain_floor();
    test_smooth_ceiling();
    test_zero_knee();
    test_random_settings(10, 130);
    test_output_holdoff();
    test_sender_pause();
    test_full_rate();
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS soft_knee_sample_limiter");
    end else begin
      $display("FAIL soft_knee_sample_limiter");
    end
    $finish;
  end

endmodule
